// ===== hw/rtl/dvrt_pkg.sv =====
package dvrt_pkg;

  localparam logic [1:0] CMD_LOOKUP     = 2'd0;
  localparam logic [1:0] CMD_ADD_LOCAL  = 2'd1;
  localparam logic [1:0] CMD_ADD_ADVERT = 2'd2;

  localparam logic [7:0] NO_HOP     = 8'hFF;
  localparam logic [7:0] MAX_WEIGHT = 8'hFF;

  // Payload of one table entry; the valid bit lives in flip-flops beside the RAM
  typedef struct packed {
    logic [7:0] hop;
    logic [7:0] weight;
  } route_data_t;

  localparam int unsigned ROUTE_DATA_W = $bits(route_data_t);

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== hw/rtl/dvrt_ram.sv =====
module dvrt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/dvrt_ctrl.sv =====
module dvrt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output dvrt_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   busy_r;

  // Accept a transaction while idle; the RAM read starts on the same edge
  assign cmd.load = start && !busy_r;
  assign cmd.exec = (state_r == ST_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd.load) begin
            state_r <= ST_EXEC;
            busy_r  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy = busy_r;

endmodule

// ===== hw/rtl/dvrt_dpath.sv =====
module dvrt_dpath #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dvrt_pkg::ctrl_cmd_t cmd,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_dest_address,
  input  logic [7:0]          in_advertiser_address,
  input  logic [7:0]          in_advertised_weight,
  output logic                out_strobe,
  output logic                out_found,
  output logic [7:0]          out_gateway,
  output logic                out_installed
);

  localparam int unsigned AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [8:0]  DEPTH_W = 9'(TABLE_DEPTH);

  logic [1:0]               cmd_r;
  logic [7:0]               dest_r;
  logic [7:0]               adv_r;
  logic [7:0]               wgt_r;
  logic [TABLE_DEPTH-1:0]   valid_r;
  logic                     strobe_r;
  logic                     found_r;
  logic [7:0]               hop_r;
  logic                     installed_r;

  dvrt_pkg::route_data_t    rd_entry;
  dvrt_pkg::route_data_t    wr_entry;
  logic [AW-1:0]            idx;
  logic                     in_range;
  logic                     hit_valid;
  logic                     is_add;
  logic [7:0]               new_weight;
  logic [7:0]               new_hop;
  logic                     install;
  logic                     lookup_hit;

  dvrt_ram #(
    .WIDTH (dvrt_pkg::ROUTE_DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (install),
    .wr_addr (idx),
    .wr_data (wr_entry),
    .rd_en   (cmd.load),
    .rd_addr (in_dest_address[AW-1:0]),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      dest_r <= in_dest_address;
      adv_r  <= in_advertiser_address;
      wgt_r  <= in_advertised_weight;
    end
  end

  assign idx       = dest_r[AW-1:0];
  assign in_range  = {1'b0, dest_r} < DEPTH_W;
  assign hit_valid = in_range && valid_r[idx];
  assign is_add    = cmd_r inside {dvrt_pkg::CMD_ADD_LOCAL, dvrt_pkg::CMD_ADD_ADVERT};

  always_comb begin
    new_weight = 8'd0;
    new_hop    = dest_r;
    case (cmd_r)
      dvrt_pkg::CMD_ADD_LOCAL: begin
        new_weight = 8'd0;
        new_hop    = dest_r;
      end
      dvrt_pkg::CMD_ADD_ADVERT: begin
        // saturate the incremented weight
        new_weight = (wgt_r == dvrt_pkg::MAX_WEIGHT) ? dvrt_pkg::MAX_WEIGHT : wgt_r + 8'd1;
        new_hop    = adv_r;
      end
      default: begin
        new_weight = 8'd0;
        new_hop    = dest_r;
      end
    endcase
  end

  // Keep a valid entry that is strictly cheaper; fill or replace otherwise
  assign install    = cmd.exec && is_add && in_range &&
                      !(hit_valid && (rd_entry.weight < new_weight));
  assign lookup_hit = (cmd_r == dvrt_pkg::CMD_LOOKUP) && hit_valid &&
                      (rd_entry.hop != dvrt_pkg::NO_HOP);

  assign wr_entry.hop    = new_hop;
  assign wr_entry.weight = new_weight;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.exec;
      if (install) begin
        valid_r[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      found_r     <= lookup_hit;
      hop_r       <= lookup_hit ? rd_entry.hop : dvrt_pkg::NO_HOP;
      installed_r <= install;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_found     = found_r;
  assign out_gateway   = hop_r;
  assign out_installed = installed_r;

`ifndef SYNTHESIS
  a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_strobe)
    else $error("result strobe missing after execute cycle");

  a_hit_has_hop: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_found |-> out_gateway != dvrt_pkg::NO_HOP && !out_installed)
    else $error("lookup hit carries no usable next hop");

  a_install_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    install |=> valid_r[$past(idx)])
    else $error("installed entry not marked valid");
`endif

endmodule

// ===== hw/rtl/distance_vector_route_table.sv =====
// Latency: a transaction accepted at one edge has its result strobed in the cycle
//   that starts at the next edge; out_strobe is high for exactly one cycle.
// Busy: no new transaction is accepted until the previous one has done the registered
//   read and the following write of the same table entry in the single route RAM.
// Reset (rst_n low, synchronous): all entry valid bits clear at once, local_address
//   returns to 0; no clearing pass. The receiver cannot stall results.
module distance_vector_route_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_dest_address,
  input  logic [7:0] in_advertiser_address,
  input  logic [7:0] in_advertised_weight,
  output logic       out_strobe,
  output logic       out_found,
  output logic [7:0] out_gateway,
  output logic       out_installed,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  dvrt_pkg::ctrl_cmd_t ctrl_cmd;
  logic [7:0]          local_address_r;

  // Node address, held for software; learned routes do not depend on it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= 8'd0;
    end else if (cfg_wr_en) begin
      local_address_r <= cfg_wr_data;
    end
  end

  dvrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (ctrl_cmd)
  );

  dvrt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (ctrl_cmd),
    .in_cmd                (in_cmd),
    .in_dest_address       (in_dest_address),
    .in_advertiser_address (in_advertiser_address),
    .in_advertised_weight  (in_advertised_weight),
    .out_strobe            (out_strobe),
    .out_found             (out_found),
    .out_gateway           (out_gateway),
    .out_installed         (out_installed)
  );

`ifndef SYNTHESIS
  a_cfg_written: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> local_address_r == $past(cfg_wr_data))
    else $error("local address not updated by configuration write");
`endif

endmodule
